FILE: rtl/assert_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("%m: forbidden condition seen");

`endif

FILE: rtl/lz4bd_pkg.sv
// Types, constants and helpers of the LZ4 block decoder.
package lz4bd_pkg;

   localparam int COUNT_BITS   = 24;
   localparam int WINDOW_BYTES = 65536;
   localparam int WIN_BITS     = $clog2(WINDOW_BYTES);
   localparam int DIST_BITS    = 16;
   localparam int LEN_BITS     = 24;
   localparam int OUTQ_DEPTH   = 3;
   localparam int PTR_BITS     = $clog2(OUTQ_DEPTH);
   localparam int CNT_BITS     = $clog2(OUTQ_DEPTH + 1);

   localparam logic [7:0] EXT_CONTINUE = 8'd255;
   localparam logic [3:0] LEN_EXTENDED = 4'd15;
   localparam logic [2:0] MIN_MATCH    = 3'd4;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_DRAIN,
      CMD_END,
      CMD_NEW
   } cmd_type;

   typedef enum logic [3:0] {
      PH_TOKEN,
      PH_LITEXT,
      PH_LIT,
      PH_OFFLO,
      PH_OFFHI,
      PH_MATCHEXT,
      PH_MATCH,
      PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_DONE,
      ST_TRUNC,
      ST_BADOFF,
      ST_OVER,
      ST_BUSY
   } status_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [WIN_BITS-1:0]   win_addr_type;

   // One accepted item on its way to the output queue.
   typedef struct packed {
      logic                valid;
      logic                emit;
      logic                from_mem;
      logic [7:0]          lit_byte;
      win_addr_type        wr_addr;
      logic                pending;
      status_type          status;
      logic [LEN_BITS-1:0] produced;
   } issue_type;

   typedef struct packed {
      logic         en;
      win_addr_type addr;
   } rd_req_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                out_valid;
      logic                match_pending;
      status_type          status;
      logic [LEN_BITS-1:0] produced;
   } rsp_type;

   // Effective capacity: register value clamped to the counter range.
   function automatic count_type cap_limit(input logic [LEN_BITS-1:0] cap);
      logic [32:0] c;
      logic [32:0] m;
      c = 33'(cap);
      m = (33'(1) << COUNT_BITS) - 33'(1);
      if (c > m) begin
         c = m;
      end
      return c[COUNT_BITS-1:0];
   endfunction

endpackage

FILE: rtl/lz4_block_decoder.sv
// An accepted transfer is registered with its history read as an issue item, then queued for rsp.
// Throughput: one transfer per cycle while req_tready is high, i.e. while the output queue has room.
// Back-to-back match drains with offset 1 are served by forwarding the byte being written.
// Reset: synchronous, active high; parser state, counters and queue cleared, capacity set to max.
// History memory is not cleared; entries are never read before the block rewrites them.
// Top level of the LZ4 block decoder.
module lz4_block_decoder (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = in_byte[7:0]; tuser = cmd[1:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   // response: tdata = out_byte[7:0], match_pending[8], status[11:9],
   //           produced[35:12], zero pad[39:36]; tuser = out_valid[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,
   // capacity register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data
);
   import lz4bd_pkg::*;

   logic [LEN_BITS-1:0] capacity_ff, capacity_in;
   logic                accept;
   issue_type           issue;
   rd_req_type          rd_req;
   logic [7:0]          hist_data;
   logic [7:0]          out_byte;
   rsp_type             rsp_in;
   rsp_type             rsp_out;
   logic [CNT_BITS-1:0] q_count;
   logic [CNT_BITS:0]   in_flight;

   // config transfers are taken at any time; the host must write only while idle, the block does not enforce it
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '1;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // room for every item in flight, so the issue stage never stalls
   assign in_flight  = (CNT_BITS + 1)'(q_count) + (CNT_BITS + 1)'(issue.valid);
   assign req_tready = (in_flight < (CNT_BITS + 1)'(OUTQ_DEPTH));
   assign accept     = req_tvalid && req_tready;

   lz4bd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (cmd_type'(req_tuser)),
      .in_byte      (req_tdata),
      .out_capacity (capacity_ff),
      .issue        (issue),
      .rd_req       (rd_req)
   );

   // literal bytes come with the item, match bytes from the history read
   assign out_byte = !issue.emit   ? 8'd0 :
                     issue.from_mem ? hist_data : issue.lit_byte;

   lz4bd_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_en   (issue.valid && issue.emit),
      .wr_addr (issue.wr_addr),
      .wr_data (out_byte),
      .rd_data (hist_data)
   );

   always_comb begin
      rsp_in.out_byte      = out_byte;
      rsp_in.out_valid     = issue.emit;
      rsp_in.match_pending = issue.pending;
      rsp_in.status        = issue.status;
      rsp_in.produced      = issue.produced;
   end

   lz4bd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (issue.valid),
      .push_data (rsp_in),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_out),
      .count     (q_count)
   );

   assign rsp_tdata = {4'd0, rsp_out.produced, rsp_out.status,
                       rsp_out.match_pending, rsp_out.out_byte};
   assign rsp_tuser = rsp_out.out_valid;

endmodule

FILE: rtl/lz4bd_hist.sv
// History window memory with write-to-read forwarding.
`include "assert_macros.svh"

module lz4bd_hist (
   input  logic                     clock,
   input  logic                     reset,
   input  lz4bd_pkg::rd_req_type    rd_req,
   input  logic                     wr_en,
   input  lz4bd_pkg::win_addr_type  wr_addr,
   input  logic [7:0]               wr_data,
   output logic [7:0]               rd_data
);
   import lz4bd_pkg::*;

   logic [7:0] mem [WINDOW_BYTES];
   logic [7:0] rdata_ff;
   logic [7:0] fwd_data_ff;
   logic       hit_ff;
   logic       hit_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_req.en) begin
         rdata_ff <= mem[rd_req.addr];
      end
      fwd_data_ff <= wr_data;
   end

   // read in the same cycle as a write to that entry sees old data: bypass
   assign hit_in = rd_req.en && wr_en && (rd_req.addr == wr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign rd_data = hit_ff ? fwd_data_ff : rdata_ff;

   `ASSERT_SYNC(a_hist_fwd, clock, reset, hit_in |=> rd_data == $past(wr_data))

endmodule

FILE: rtl/lz4bd_outq.sv
// Three-entry result queue between the decoder and the result channel.
`include "assert_macros.svh"

module lz4bd_outq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  lz4bd_pkg::rsp_type               push_data,
   input  logic                             pop_ready,
   output logic                             out_valid,
   output lz4bd_pkg::rsp_type               out_data,
   output logic [lz4bd_pkg::CNT_BITS-1:0]   count
);
   import lz4bd_pkg::*;

   rsp_type               slot_ff [OUTQ_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && pop_ready;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_outq_overflow, clock, reset, push && !pop && count_ff == CNT_BITS'(OUTQ_DEPTH))

endmodule

FILE: rtl/lz4bd_ctrl.sv
// Sequence parser: token, lengths, offset, match drain and block status.
`include "assert_macros.svh"

module lz4bd_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  lz4bd_pkg::cmd_type               cmd,
   input  logic [7:0]                       in_byte,
   input  logic [lz4bd_pkg::LEN_BITS-1:0]   out_capacity,
   output lz4bd_pkg::issue_type             issue,
   output lz4bd_pkg::rd_req_type            rd_req
);
   import lz4bd_pkg::*;

   phase_type              phase_ff, phase_in;
   count_type              literal_left_ff, literal_left_in;
   count_type              match_left_ff, match_left_in;
   logic [DIST_BITS-1:0]   match_distance_ff, match_distance_in;
   logic [3:0]             match_code_ff, match_code_in;
   logic [7:0]             offset_low_ff, offset_low_in;
   count_type              produced_ff, produced_in;
   status_type             status_ff, status_in;
   issue_type              issue_ff, issue_in;

   count_type              cap;
   count_type              room;
   logic                   emit;
   logic                   from_mem;
   logic                   busy;

   always_comb begin
      cap  = cap_limit(out_capacity);
      room = (produced_ff >= cap) ? '0 : cap - produced_ff;
   end

   // outputs of the step
   always_comb begin
      emit     = 1'b0;
      from_mem = 1'b0;
      busy     = 1'b0;
      if (status_ff == ST_OK) begin
         unique case (cmd)
            CMD_BYTE: begin
               if (phase_ff == PH_MATCH) begin
                  busy = 1'b1;
               end else if (phase_ff == PH_LIT) begin
                  emit = 1'b1;
               end
            end
            CMD_DRAIN: begin
               if (phase_ff == PH_MATCH) begin
                  emit     = 1'b1;
                  from_mem = 1'b1;
               end
            end
            CMD_END: begin
               busy = (phase_ff == PH_MATCH);
            end
            CMD_NEW: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      logic [COUNT_BITS:0]    lit_sum;
      logic [COUNT_BITS:0]    match_sum;
      count_type              tok_lit;
      logic [DIST_BITS-1:0]   offset_val;

      phase_in          = phase_ff;
      literal_left_in   = literal_left_ff;
      match_left_in     = match_left_ff;
      match_distance_in = match_distance_ff;
      match_code_in     = match_code_ff;
      offset_low_in     = offset_low_ff;
      produced_in       = produced_ff;
      status_in         = status_ff;

      lit_sum    = {1'b0, literal_left_ff} + (COUNT_BITS + 1)'(in_byte);
      match_sum  = {1'b0, match_left_ff} + (COUNT_BITS + 1)'(in_byte);
      tok_lit    = COUNT_BITS'(in_byte[7:4]);
      offset_val = {in_byte, offset_low_ff};

      if (accept) begin
         if (cmd == CMD_NEW) begin
            phase_in          = PH_TOKEN;
            literal_left_in   = '0;
            match_left_in     = '0;
            match_distance_in = '0;
            match_code_in     = '0;
            offset_low_in     = '0;
            produced_in       = '0;
            status_in         = ST_OK;
         end else if (status_ff == ST_OK) begin
            if (cmd == CMD_BYTE) begin
               unique case (phase_ff)
                  PH_TOKEN: begin
                     match_code_in   = in_byte[3:0];
                     literal_left_in = tok_lit;
                     if (tok_lit > room) begin
                        status_in = ST_OVER;
                        phase_in  = PH_HALT;
                     end else if (in_byte[7:4] == LEN_EXTENDED) begin
                        phase_in = PH_LITEXT;
                     end else if (in_byte[7:4] == 4'd0) begin
                        phase_in = PH_OFFLO;
                     end else begin
                        phase_in = PH_LIT;
                     end
                  end
                  PH_LITEXT: begin
                     literal_left_in = lit_sum[COUNT_BITS-1:0];
                     if (lit_sum > {1'b0, room}) begin
                        status_in = ST_OVER;
                        phase_in  = PH_HALT;
                     end else if (in_byte != EXT_CONTINUE) begin
                        phase_in = PH_LIT;
                     end
                  end
                  PH_LIT: begin
                     literal_left_in = literal_left_ff - 1'b1;
                     if (literal_left_ff == COUNT_BITS'(1)) begin
                        phase_in = PH_OFFLO;
                     end
                  end
                  PH_OFFLO: begin
                     offset_low_in = in_byte;
                     phase_in      = PH_OFFHI;
                  end
                  PH_OFFHI: begin
                     match_distance_in = offset_val;
                     if (offset_val == '0 || COUNT_BITS'(offset_val) > produced_ff) begin
                        status_in = ST_BADOFF;
                        phase_in  = PH_HALT;
                     end else begin
                        // match length is token code plus minimum, checked at once
                        match_left_in = COUNT_BITS'(match_code_ff) + COUNT_BITS'(MIN_MATCH);
                        if (COUNT_BITS'(match_code_ff) + COUNT_BITS'(MIN_MATCH) > room) begin
                           status_in = ST_OVER;
                           phase_in  = PH_HALT;
                        end else if (match_code_ff == LEN_EXTENDED) begin
                           phase_in = PH_MATCHEXT;
                        end else begin
                           phase_in = PH_MATCH;
                        end
                     end
                  end
                  PH_MATCHEXT: begin
                     match_left_in = match_sum[COUNT_BITS-1:0];
                     if (match_sum > {1'b0, room}) begin
                        status_in = ST_OVER;
                        phase_in  = PH_HALT;
                     end else if (in_byte != EXT_CONTINUE) begin
                        phase_in = PH_MATCH;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end else if (cmd == CMD_DRAIN) begin
               if (phase_ff == PH_MATCH) begin
                  match_left_in = match_left_ff - 1'b1;
                  if (match_left_ff == COUNT_BITS'(1)) begin
                     phase_in = PH_TOKEN;
                  end
               end
            end else begin
               if (phase_ff == PH_TOKEN || phase_ff == PH_OFFLO) begin
                  status_in = ST_DONE;
                  phase_in  = PH_HALT;
               end else if (phase_ff != PH_MATCH) begin
                  status_in = ST_TRUNC;
                  phase_in  = PH_HALT;
               end
            end
            if (emit) begin
               produced_in = produced_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      issue_in.valid    = accept;
      issue_in.emit     = accept && emit;
      issue_in.from_mem = from_mem;
      issue_in.lit_byte = in_byte;
      issue_in.wr_addr  = produced_ff[WIN_BITS-1:0];
      issue_in.pending  = (phase_in == PH_MATCH);
      issue_in.status   = busy ? ST_BUSY : status_in;
      issue_in.produced = LEN_BITS'(produced_in);
   end

   assign rd_req.en   = accept && from_mem;
   assign rd_req.addr = produced_ff[WIN_BITS-1:0] - WIN_BITS'(match_distance_ff);
   assign issue       = issue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_TOKEN;
         literal_left_ff   <= '0;
         match_left_ff     <= '0;
         match_distance_ff <= '0;
         match_code_ff     <= '0;
         offset_low_ff     <= '0;
         produced_ff       <= '0;
         status_ff         <= ST_OK;
         issue_ff          <= '0;
      end else begin
         phase_ff          <= phase_in;
         literal_left_ff   <= literal_left_in;
         match_left_ff     <= match_left_in;
         match_distance_ff <= match_distance_in;
         match_code_ff     <= match_code_in;
         offset_low_ff     <= offset_low_in;
         produced_ff       <= produced_in;
         status_ff         <= status_in;
         issue_ff          <= issue_in;
      end
   end

   `ASSERT_SYNC(a_ctrl_sticky, clock, reset, accept && cmd != CMD_NEW && status_ff != ST_OK |=> $stable(status_ff) && $stable(produced_ff))

endmodule
